// File: rtl/assert_macros.svh
// Assertion macros used by the checker file u8lc_checker.sv.
// Each macro expands to one labeled concurrent assertion, reset-gated.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while rst is high.
`define U8_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Signal holds its value in the cycle after cond.
`define U8_ASSERT_HOLD(label, clk, rst, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/u8lc_pkg.sv
// Shared types and constants for the UTF-8 offset to line / UTF-16 column block.
// No dependencies.
package u8lc_pkg;

  localparam int FIELD_W = 24;  // width of the result fields
  localparam int CODE_W  = 21;  // partial code point
  localparam int AMT_W   = 4;   // per-byte unit increment

  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [CODE_W-1:0] ASTRAL_MIN = 21'h10000;

  typedef struct packed {
    logic       is_newline;
    logic       is_cont;
    logic [1:0] follow;     // continuations a lead asks for, 0 if not a lead
    logic [4:0] lead_bits;  // payload bits of the lead
  } byte_class_t;

  typedef struct packed {
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] utf16_column;
    logic               offset_clamped;
  } result_t;

endpackage

// File: rtl/u8lc_decode.sv
// Byte classifier: newline, continuation, lead length and lead payload bits.
// Depends on u8lc_pkg.
module u8lc_decode import u8lc_pkg::*; (
  input  logic [7:0]  text_byte,
  output byte_class_t cls
);

  always_comb begin
    cls.is_newline = (text_byte == NEWLINE);
    cls.is_cont    = ((text_byte & CONT_MASK) == CONT_TAG);
    cls.follow     = 2'd0;
    cls.lead_bits  = 5'd0;
    // 0xF8..0xFF fall in with the four-byte leads
    if (text_byte >= LEAD4_MIN) begin
      cls.follow    = 2'd3;
      cls.lead_bits = {2'b00, text_byte[2:0]};
    end else if (text_byte >= LEAD3_MIN) begin
      cls.follow    = 2'd2;
      cls.lead_bits = {1'b0, text_byte[3:0]};
    end else if (text_byte >= LEAD2_MIN) begin
      cls.follow    = 2'd1;
      cls.lead_bits = text_byte[4:0];
    end
  end

endmodule

// File: rtl/u8lc_core.sv
// Per-text counting state and its per-byte update; builds the result.
// Depends on u8lc_pkg; fed by u8lc_decode.
module u8lc_core import u8lc_pkg::*; #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step_en,
  input  logic [7:0]             text_byte,
  input  logic                   last_byte,
  input  byte_class_t            cls,
  input  logic [OFFSET_BITS-1:0] target,
  output logic                   fire,
  output result_t                res
);

  localparam int IDX_W = OFFSET_BITS + 1;
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
  localparam logic [IDX_W-1:0]       IDX_MAX = '1;

  logic [IDX_W-1:0]       byte_index;
  logic [OFFSET_BITS-1:0] newline_count;
  logic [OFFSET_BITS-1:0] unit_column;
  logic [1:0]             pending_follow;
  logic [1:0]             continuations_seen;
  logic [CODE_W-1:0]      code_accum;
  logic                   result_given;

  logic [IDX_W-1:0]       byte_index_next;
  logic [OFFSET_BITS-1:0] newline_count_next;
  logic [OFFSET_BITS-1:0] unit_column_next;
  logic [1:0]             pending_follow_next;
  logic [1:0]             continuations_seen_next;
  logic [CODE_W-1:0]      code_accum_next;

  logic [IDX_W-1:0]       tgt_x;
  logic                   before_tgt, seq_open, complete, broken, fresh_act, nl_hit, settle;
  logic [1:0]             seen_inc, credit_mid, credit_end;
  logic [CODE_W-1:0]      acc_ext;
  logic [AMT_W-1:0]       add_amt, tail_amt;
  logic [OFFSET_BITS:0]   col_sum, out_sum;
  logic [OFFSET_BITS-1:0] col_out;

  // Units credited to the continuations of a broken sequence that lie before
  // the target. pos is the position just past the last continuation read.
  function automatic logic [1:0] break_credit(input logic [1:0] seen,
                                              input logic [IDX_W-1:0] pos,
                                              input logic [IDX_W-1:0] tgt);
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] diff;
    first = (pos >= IDX_W'(seen)) ? pos - IDX_W'(seen) : '0;
    diff  = tgt - first;
    if (pos <= tgt) begin
      return seen;
    end else if (first >= tgt) begin
      return 2'd0;
    end else begin
      return diff[1:0];
    end
  endfunction

  always_comb begin
    tgt_x      = IDX_W'(target);
    before_tgt = (byte_index < tgt_x);
    seq_open   = (pending_follow != 2'd0);
    acc_ext    = {code_accum[CODE_W-7:0], text_byte[5:0]};
    seen_inc   = continuations_seen + 2'd1;
    complete   = seq_open && cls.is_cont && (seen_inc >= pending_follow);
    broken     = seq_open && !cls.is_cont;
    fresh_act  = (!seq_open || broken) && before_tgt;
    nl_hit     = fresh_act && cls.is_newline;
    credit_mid = break_credit(continuations_seen, byte_index, tgt_x);

    add_amt = '0;
    if (complete) begin
      add_amt = (acc_ext >= ASTRAL_MIN) ? AMT_W'(2) : AMT_W'(1);
    end else if (broken) begin
      add_amt = AMT_W'(1) + AMT_W'(credit_mid);
    end
    // a plain byte (bare continuation or ASCII) counts one unit
    if (fresh_act && !cls.is_newline && cls.follow == 2'd0) begin
      add_amt = add_amt + AMT_W'(1);
    end

    pending_follow_next     = 2'd0;
    continuations_seen_next = 2'd0;
    code_accum_next         = '0;
    if (seq_open && cls.is_cont && !complete) begin
      pending_follow_next     = pending_follow;
      continuations_seen_next = seen_inc;
      code_accum_next         = acc_ext;
    end else if (fresh_act && cls.follow != 2'd0) begin
      pending_follow_next = cls.follow;
      code_accum_next     = CODE_W'(cls.lead_bits);
    end

    if (nl_hit && newline_count != OFS_MAX) begin
      newline_count_next = newline_count + 1'b1;
    end else begin
      newline_count_next = newline_count;
    end

    col_sum = {1'b0, unit_column} + (OFFSET_BITS+1)'(add_amt);
    if (nl_hit) begin
      unit_column_next = '0;
    end else if (col_sum[OFFSET_BITS]) begin
      unit_column_next = OFS_MAX;
    end else begin
      unit_column_next = col_sum[OFFSET_BITS-1:0];
    end

    byte_index_next = (byte_index == IDX_MAX) ? byte_index : byte_index + 1'b1;
    settle = !result_given && (pending_follow_next == 2'd0) && (byte_index_next >= tgt_x);
    fire   = step_en && !result_given && (settle || last_byte);

    // on the last byte a still-open sequence is resolved as truncated
    credit_end = break_credit(continuations_seen_next, byte_index_next, tgt_x);
    tail_amt   = (last_byte && pending_follow_next != 2'd0)
                 ? AMT_W'(1) + AMT_W'(credit_end) : '0;
    out_sum    = {1'b0, unit_column} + (OFFSET_BITS+1)'(add_amt)
                 + (OFFSET_BITS+1)'(tail_amt);
    if (nl_hit) begin
      col_out = '0;
    end else if (out_sum[OFFSET_BITS]) begin
      col_out = OFS_MAX;
    end else begin
      col_out = out_sum[OFFSET_BITS-1:0];
    end

    res.line_number    = FIELD_W'(newline_count_next);
    res.utf16_column   = FIELD_W'(col_out);
    res.offset_clamped = (byte_index_next < tgt_x);
  end

  always_ff @(posedge clk) begin
    if (rst || (step_en && last_byte)) begin
      byte_index         <= '0;
      newline_count      <= '0;
      unit_column        <= '0;
      pending_follow     <= 2'd0;
      continuations_seen <= 2'd0;
      code_accum         <= '0;
      result_given       <= 1'b0;
    end else if (step_en) begin
      byte_index         <= byte_index_next;
      newline_count      <= newline_count_next;
      unit_column        <= unit_column_next;
      pending_follow     <= pending_follow_next;
      continuations_seen <= continuations_seen_next;
      code_accum         <= code_accum_next;
      result_given       <= result_given | settle;
    end
  end

endmodule

// File: rtl/utf8_offset_to_line_utf16_column_top.sv
// UTF-8 byte offset to line number and UTF-16 column; top level.
// The result passes through the item register, then the result register.
// Throughput: one text byte per cycle while the result register is not blocked; one counter update per byte.
// Reset (rst, synchronous): clears both pipeline valids, the text state, and
// target_offset to 0. Uses u8lc_pkg, u8lc_decode, u8lc_core.
module utf8_offset_to_line_utf16_column_top import u8lc_pkg::*; #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   target_offset_write,
  input  logic [OFFSET_BITS-1:0] target_offset_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FIELD_W-1:0]     line_number,
  output logic [FIELD_W-1:0]     utf16_column,
  output logic                   offset_clamped
);

  logic [OFFSET_BITS-1:0] target_offset;
  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_last;
  logic                   advance;
  logic                   fire;
  byte_class_t            cls;
  result_t                res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_offset <= '0;
    end else if (target_offset_write) begin
      target_offset <= target_offset_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_byte <= text_byte;
      in_q_last <= last_byte;
    end
  end

  u8lc_decode u_decode (
    .text_byte (in_q_byte),
    .cls       (cls)
  );

  u8lc_core #(.OFFSET_BITS(OFFSET_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (in_q_valid && advance),
    .text_byte (in_q_byte),
    .last_byte (in_q_last),
    .cls       (cls),
    .target    (target_offset),
    .fire      (fire),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      line_number    <= res.line_number;
      utf16_column   <= res.utf16_column;
      offset_clamped <= res.offset_clamped;
    end
  end

endmodule

// File: rtl/u8lc_checker.sv
// Port-level checker for utf8_offset_to_line_utf16_column_top, bound to it below.
// Depends on u8lc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8lc_checker import u8lc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FIELD_W-1:0] line_number,
  input logic [FIELD_W-1:0] utf16_column,
  input logic               offset_clamped
);

  logic [2*FIELD_W+1:0] out_word;
  logic                 in_take;

  assign out_word = {out_valid, line_number, utf16_column, offset_clamped};
  assign in_take  = in_valid && !in_stall;

  // a stalled result stays put
  `U8_ASSERT_HOLD(a_out_hold, clk, rst, out_valid && out_stall, out_word, "stalled result changed")

  // input side only backs up when the result register is blocked
  `U8_ASSERT(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall), "stray in_stall")

  // nothing is shown right after reset
  `U8_ASSERT(a_reset_clear, clk, rst, $past(rst) |-> !out_valid, "result valid right after reset")

  // a new result rises only after an item was taken and passed the item and result registers
  `U8_ASSERT(a_latency, clk, rst, $rose(out_valid) |-> $past(in_take, 2), "result without item")

endmodule

bind utf8_offset_to_line_utf16_column_top u8lc_checker u_u8lc_checker (.*);

// File: test/utf8_offset_to_line_utf16_column_top_test.sv
// Testbench for utf8_offset_to_line_utf16_column_top: drives UTF-8 texts byte by byte,
// predicts line number and UTF-16 column per text, and checks every result item.
// Depends on u8lc_pkg and the top level only.
`timescale 1ns / 100ps

module utf8_offset_to_line_utf16_column_top_test;
  import u8lc_pkg::*;

  localparam int OFFSET_BITS = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int TOTAL_ITEMS = 1300;
  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  typedef struct {
    bit                     is_cfg;
    logic [OFFSET_BITS-1:0] value;
    logic [7:0]             data;
    bit                     last;
    bit                     typed;
    result_t                want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   target_offset_write = 1'b0;
  logic [OFFSET_BITS-1:0] target_offset_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             text_byte = '0;
  logic                   last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FIELD_W-1:0]     line_number;
  logic [FIELD_W-1:0]     utf16_column;
  logic                   offset_clamped;

  utf8_offset_to_line_utf16_column_top #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk                 (clk),
    .rst                 (rst),
    .target_offset_write (target_offset_write),
    .target_offset_data  (target_offset_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .text_byte           (text_byte),
    .last_byte           (last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .line_number         (line_number),
    .utf16_column        (utf16_column),
    .offset_clamped      (offset_clamped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Position tracker state
  logic [OFFSET_BITS-1:0] target;
  logic [OFFSET_BITS:0]   pos_count;
  logic [FIELD_W-1:0]     nl_count;
  logic [FIELD_W-1:0]     col_units;
  logic [1:0]             cont_need;
  logic [1:0]             cont_seen;
  logic [CODE_W-1:0]      code_part;
  bit                     settled;

  result_t    positions_due[$];
  logic [7:0] text_q[$];
  int         items_sent = 0;
  int         mismatches = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         hold_req = 1'b0;

  function automatic void clear_text();
    pos_count = '0;
    nl_count  = '0;
    col_units = '0;
    cont_need = '0;
    cont_seen = '0;
    code_part = '0;
    settled   = 1'b0;
  endfunction

  function automatic void add_units(input int unsigned n);
    logic [31:0] s;
    s = col_units + n;
    col_units = (s > FIELD_MAX) ? FIELD_MAX : s[FIELD_W-1:0];
  endfunction

  // Broken sequence: lead counts one, plus continuations read before the target.
  function automatic void close_broken(input logic [OFFSET_BITS:0] p);
    logic [OFFSET_BITS:0] first;
    logic [OFFSET_BITS:0] credit;
    first = (p >= cont_seen) ? p - cont_seen : '0;
    if (p <= target) credit = (OFFSET_BITS+1)'(cont_seen);
    else if (first >= target) credit = '0;
    else credit = target - first;
    add_units(1 + credit);
    cont_need = '0;
    cont_seen = '0;
    code_part = '0;
  endfunction

  function automatic void fresh_byte(input logic [7:0] b, input logic [OFFSET_BITS:0] p);
    if (p >= target) return;
    if (b == NEWLINE) begin
      if (nl_count != FIELD_MAX) nl_count = nl_count + 1'b1;
      col_units = '0;
    end else if (b >= LEAD4_MIN) begin
      cont_need = 2'd3;
      code_part = CODE_W'(b[2:0]);
      cont_seen = '0;
    end else if (b >= LEAD3_MIN) begin
      cont_need = 2'd2;
      code_part = CODE_W'(b[3:0]);
      cont_seen = '0;
    end else if (b >= LEAD2_MIN) begin
      cont_need = 2'd1;
      code_part = CODE_W'(b[4:0]);
      cont_seen = '0;
    end else begin
      add_units(1);
    end
  endfunction

  function automatic void track_byte(input logic [7:0] b, input bit last,
                                     output bit got, output result_t r);
    logic [OFFSET_BITS:0] p;
    p = pos_count;
    got = 1'b0;
    r = '0;
    if (cont_need != 0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        code_part = (code_part << 6) | b[5:0];
        cont_seen = cont_seen + 1'b1;
        if (cont_seen >= cont_need) begin
          add_units(code_part >= ASTRAL_MIN ? 2 : 1);
          cont_need = '0;
          cont_seen = '0;
          code_part = '0;
        end
      end else begin
        close_broken(p);
        fresh_byte(b, p);
      end
    end else begin
      fresh_byte(b, p);
    end
    pos_count = (p != '1) ? p + 1'b1 : p;
    if (!settled && cont_need == 0 && pos_count >= target) begin
      r = '{line_number: nl_count, utf16_column: col_units, offset_clamped: 1'b0};
      settled = 1'b1;
      got = 1'b1;
    end
    if (last) begin
      if (cont_need != 0) close_broken(pos_count);
      if (!settled) begin
        r = '{line_number: nl_count, utf16_column: col_units,
              offset_clamped: pos_count < target};
        got = 1'b1;
      end
      clear_text();
    end
  endfunction

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (positions_due.size() == 0) begin
        flag_error($sformatf("unexpected item line=%0d col=%0d clamped=%0b",
                             line_number, utf16_column, offset_clamped));
      end else begin
        want = positions_due.pop_front();
        if (line_number !== want.line_number || utf16_column !== want.utf16_column ||
            offset_clamped !== want.offset_clamped)
          flag_error($sformatf("expected line=%0d col=%0d clamped=%0b, got %0d %0d %0b",
                               want.line_number, want.utf16_column, want.offset_clamped,
                               line_number, utf16_column, offset_clamped));
      end
    end
  end

  // Receiver: random stall, or one long hold counted here
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input bit last, input bit typed,
                           input result_t want);
    bit      got;
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, last, got, r);
    if (typed) positions_due.push_back(want);
    else if (got) positions_due.push_back(r);
    items_sent++;
  endtask

  // Target may only change with nothing in flight: pause, drain, then let the pipe empty.
  task automatic set_target(input logic [OFFSET_BITS-1:0] v);
    in_valid <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    target_offset_write <= 1'b1;
    target_offset_data  <= v;
    @(posedge clk);
    target_offset_write <= 1'b0;
    target = v;
  endtask

  function automatic logic [OFFSET_BITS-1:0] pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    if (r < 20) return OFFSET_BITS'($urandom());
    return OFFSET_BITS'($urandom_range(0, 40));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic void gen_text(input int n_chars);
    int         kind;
    int         need;
    logic [7:0] lead;
    text_q.delete();
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 45) begin
        text_q.push_back(NEWLINE);
      end else if (kind < 55) begin
        text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_q.push_back(cont_byte());
      end else if (kind < 65) begin
        text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) text_q.push_back(cont_byte());
      end else if (kind < 75) begin
        text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        repeat (3) text_q.push_back(cont_byte());
      end else if (kind < 80) begin
        // leads above F7 still act as four-byte leads
        text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        repeat (3) text_q.push_back(cont_byte());
      end else if (kind < 85) begin
        text_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
        text_q.push_back(cont_byte());
      end else if (kind < 90) begin
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        need = (lead >= LEAD4_MIN) ? 3 : (lead >= LEAD3_MIN) ? 2 : 1;
        text_q.push_back(lead);
        repeat ($urandom_range(0, need - 1)) text_q.push_back(cont_byte());
      end else if (kind < 95) begin
        text_q.push_back(cont_byte());
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic send_text();
    int change_at;
    change_at = (text_q.size() > 2 && $urandom_range(14) == 0) ?
                $urandom_range(1, text_q.size() - 1) : -1;
    for (int i = 0; i < text_q.size(); i++) begin
      if (i == change_at) set_target(pick_target());
      send_item(text_q[i], i == text_q.size() - 1, 1'b0, '0);
    end
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) begin
      if ($urandom_range(3) == 0) set_target(pick_target());
      gen_text(($urandom_range(19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12));
      send_text();
    end
  endtask

  plan_row_t plan [0:28] = '{
    // target zero after reset: settles on the first byte
    '{1'b0, 24'd0, 8'h41, 1'b0, 1'b1, '{24'd0, 24'd0, 1'b0}},
    '{1'b0, 24'd0, 8'h0A, 1'b1, 1'b0, '0},
    // newline then a four-byte sequence (two units)
    '{1'b1, 24'd5, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h61, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h0A, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hF0, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h9F, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h98, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h41, 1'b1, 1'b0, '0},
    // three-byte lead broken after one continuation
    '{1'b1, 24'd3, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hE2, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h82, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h41, 1'b1, 1'b1, '{24'd0, 24'd3, 1'b0}},
    // target past the end, text ends on an open lead
    '{1'b1, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hC3, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hA9, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hC0, 1'b1, 1'b1, '{24'd0, 24'd2, 1'b1}},
    // bare continuation, F8 lead broken by a newline past the target
    '{1'b1, 24'd2, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hBF, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'hF8, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h0A, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h41, 1'b1, 1'b0, '0},
    // broken sequence straddling the target: partial credit
    '{1'b0, 24'd0, 8'hF0, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h80, 1'b0, 1'b0, '0},
    '{1'b0, 24'd0, 8'h41, 1'b1, 1'b0, '0}
  };

  initial begin
    int wait_cycles;
    target = '0;
    clear_text();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_target(plan[i].value);
      else send_item(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
    end

    tx_idle_pct = 26;
    rx_idle_pct = 75;
    run_random(items_sent + (TOTAL_ITEMS - items_sent) / 3);
    tx_idle_pct = 75;
    rx_idle_pct = 26;
    run_random(items_sent + (TOTAL_ITEMS - items_sent) / 2);
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // long receiver hold while short texts keep coming, so the block backs up
    set_target(24'd1);
    hold_req = 1'b1;
    repeat (40) begin
      gen_text($urandom_range(1, 2));
      send_text();
    end
    run_random(TOTAL_ITEMS);

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (positions_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (positions_due.size() != 0)
      flag_error($sformatf("%0d expected items never arrived", positions_due.size()));
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
